>>> design/lcd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lcd_pkg
// Shared types, codes and the 5x7 font table of the LCD text command stream.
// ---------------------------------------------------------------------------
package lcd_pkg;

    localparam int COLUMNS_DEF = 84;
    localparam int BANKS_DEF   = 6;

    // Request codes.
    typedef enum logic [2:0] {
        CMD_INIT   = 3'd0,
        CMD_OCTET  = 3'd1,
        CMD_CHAR   = 3'd2,
        CMD_DEC    = 3'd3,
        CMD_CURSOR = 3'd4
    } cmd_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_CONTRAST = 2'd0;
    localparam logic [1:0] REG_TEMP     = 2'd1;
    localparam logic [1:0] REG_BIAS     = 2'd2;
    localparam logic [1:0] REG_INVERSE  = 2'd3;

    // Digit memory: one entry per displayed character position.
    localparam int DIG_DEPTH = 5;
    localparam int DIG_AW    = 3;
    localparam int DIG_W     = 8;

    // Powers of ten used by the digit extractor.
    function automatic logic [13:0] pow10(input logic [2:0] k);
        logic [13:0] p;
        begin
            unique case (k)
                3'd0:    p = 14'd10000;
                3'd1:    p = 14'd1000;
                3'd2:    p = 14'd100;
                3'd3:    p = 14'd10;
                default: p = 14'd1;
            endcase
            return p;
        end
    endfunction

    // Font column lookup; codes outside the printable range are blank.
    function automatic logic [7:0] glyph_col(input logic [7:0] code,
                                             input logic [2:0] col);
        logic [39:0] g;
        begin
            unique case (code)
                8'h20: g = 40'h0000000000; 8'h21: g = 40'h00005f0000;
                8'h22: g = 40'h0007000700; 8'h23: g = 40'h147f147f14;
                8'h24: g = 40'h242a7f2a12; 8'h25: g = 40'h2313086462;
                8'h26: g = 40'h3649552250; 8'h27: g = 40'h0005030000;
                8'h28: g = 40'h001c224100; 8'h29: g = 40'h0041221c00;
                8'h2a: g = 40'h14083e0814; 8'h2b: g = 40'h08083e0808;
                8'h2c: g = 40'h0050300000; 8'h2d: g = 40'h0808080808;
                8'h2e: g = 40'h0060600000; 8'h2f: g = 40'h2010080402;
                8'h30: g = 40'h3e5149453e; 8'h31: g = 40'h00427f4000;
                8'h32: g = 40'h4261514946; 8'h33: g = 40'h2141454b31;
                8'h34: g = 40'h1814127f10; 8'h35: g = 40'h2745454539;
                8'h36: g = 40'h3c4a494930; 8'h37: g = 40'h0171090503;
                8'h38: g = 40'h3649494936; 8'h39: g = 40'h064949291e;
                8'h3a: g = 40'h0036360000; 8'h3b: g = 40'h0056360000;
                8'h3c: g = 40'h0814224100; 8'h3d: g = 40'h1414141414;
                8'h3e: g = 40'h0041221408; 8'h3f: g = 40'h0201510906;
                8'h40: g = 40'h324979413e; 8'h41: g = 40'h7e1111117e;
                8'h42: g = 40'h7f49494936; 8'h43: g = 40'h3e41414122;
                8'h44: g = 40'h7f4141221c; 8'h45: g = 40'h7f49494941;
                8'h46: g = 40'h7f09090901; 8'h47: g = 40'h3e4149497a;
                8'h48: g = 40'h7f0808087f; 8'h49: g = 40'h00417f4100;
                8'h4a: g = 40'h2040413f01; 8'h4b: g = 40'h7f08142241;
                8'h4c: g = 40'h7f40404040; 8'h4d: g = 40'h7f020c027f;
                8'h4e: g = 40'h7f0408107f; 8'h4f: g = 40'h3e4141413e;
                8'h50: g = 40'h7f09090906; 8'h51: g = 40'h3e4151215e;
                8'h52: g = 40'h7f09192946; 8'h53: g = 40'h4649494931;
                8'h54: g = 40'h01017f0101; 8'h55: g = 40'h3f4040403f;
                8'h56: g = 40'h1f2040201f; 8'h57: g = 40'h3f4038403f;
                8'h58: g = 40'h6314081463; 8'h59: g = 40'h0708700807;
                8'h5a: g = 40'h6151494543; 8'h5b: g = 40'h007f414100;
                8'h5c: g = 40'h0204081020; 8'h5d: g = 40'h0041417f00;
                8'h5e: g = 40'h0402010204; 8'h5f: g = 40'h4040404040;
                8'h60: g = 40'h0001020400; 8'h61: g = 40'h2054545478;
                8'h62: g = 40'h7f48444438; 8'h63: g = 40'h3844444420;
                8'h64: g = 40'h384444487f; 8'h65: g = 40'h3854545418;
                8'h66: g = 40'h087e090102; 8'h67: g = 40'h0c5252523e;
                8'h68: g = 40'h7f08040478; 8'h69: g = 40'h00447d4000;
                8'h6a: g = 40'h2040443d00; 8'h6b: g = 40'h7f10284400;
                8'h6c: g = 40'h00417f4000; 8'h6d: g = 40'h7c04180478;
                8'h6e: g = 40'h7c08040478; 8'h6f: g = 40'h3844444438;
                8'h70: g = 40'h7c14141408; 8'h71: g = 40'h081414187c;
                8'h72: g = 40'h7c08040408; 8'h73: g = 40'h4854545420;
                8'h74: g = 40'h043f444020; 8'h75: g = 40'h3c4040207c;
                8'h76: g = 40'h1c2040201c; 8'h77: g = 40'h3c4030403c;
                8'h78: g = 40'h4428102844; 8'h79: g = 40'h0c5050503c;
                8'h7a: g = 40'h4464544c44; 8'h7b: g = 40'h0008364100;
                8'h7c: g = 40'h00007f0000; 8'h7d: g = 40'h0041360800;
                8'h7e: g = 40'h1008081008;
                default: g = 40'h0;
            endcase
            unique case (col)
                3'd0:    return g[39:32];
                3'd1:    return g[31:24];
                3'd2:    return g[23:16];
                3'd3:    return g[15:8];
                default: return g[7:0];
            endcase
        end
    endfunction

endpackage
`default_nettype wire

>>> design/lcd_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lcd_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module lcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 5
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> design/lcd_digits.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lcd_digits
// Splits a 16-bit value into five character codes, one digit per step by
// repeated subtraction of a power of ten, and writes them to the memory.
// ---------------------------------------------------------------------------
module lcd_digits
    import lcd_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                go,
    input  wire logic [15:0]         value,
    output logic                     done,
    output logic                     we,
    output logic      [DIG_AW-1:0]   waddr,
    output logic      [DIG_W-1:0]    wdata
);

    typedef enum logic [0:0] { S_IDLE, S_RUN } state_t;

    state_t           state_reg, state_next;
    logic [16:0]      rest_reg, rest_next;
    logic [2:0]       k_reg, k_next;
    logic [3:0]       d_reg, d_next;
    logic             started_reg, started_next;
    logic [16:0]      diff;
    logic             emit;

    // One subtraction per cycle; a digit is emitted when the rest drops below.
    always_comb
    begin
        diff         = rest_reg - {3'd0, pow10(k_reg)};
        state_next   = state_reg;
        rest_next    = rest_reg;
        k_next       = k_reg;
        d_next       = d_reg;
        started_next = started_reg;
        emit         = 1'b0;
        done         = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (go)
                begin
                    state_next   = S_RUN;
                    rest_next    = {1'b0, value};
                    k_next       = 3'd0;
                    d_next       = 4'd0;
                    started_next = 1'b0;
                end
            end
            S_RUN:
            begin
                if (!diff[16])
                begin
                    rest_next = diff;
                    d_next    = d_reg + 4'd1;
                end
                else
                begin
                    emit         = 1'b1;
                    started_next = started_reg | (d_reg != 4'd0) | (k_reg == 3'd4);
                    d_next       = 4'd0;
                    k_next       = k_reg + 3'd1;
                    if (k_reg == 3'd4)
                    begin
                        state_next = S_IDLE;
                        done       = 1'b1;
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign we    = emit;
    assign waddr = k_reg;
    assign wdata = (started_reg | (d_reg != 4'd0) | (k_reg == 3'd4))
                   ? {4'h3, d_reg} : 8'h20;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            rest_reg    <= '0;
            k_reg       <= '0;
            d_reg       <= '0;
            started_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rest_reg    <= rest_next;
            k_reg       <= k_next;
            d_reg       <= d_next;
            started_reg <= started_next;
        end
    end

endmodule
`default_nettype wire

>>> design/lcd_text_command_stream_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// lcd_text_command_stream_unit
// Turns display requests into command and data words for a graphic LCD.
// ---------------------------------------------------------------------------
// Usage:
// A request (command, value, cursor_x, cursor_y) is taken at a clock edge
// with start high and busy low. The block then raises busy and puts out one
// word per cycle on is_data/byte_out, marked by strobe; last marks the final
// word of the request. The receiver cannot stall the stream.
// Init gives 6 words, raw octet 1, character 7, cursor 2 or none.
// Other than for a decimal, the first word is put out by the word registers
// from the streaming state that follows acceptance; a request that gives no
// word only holds busy through the flush state. A decimal request first
// splits the value into five character codes held in a small digit memory
// (one subtraction per cycle), then streams 35 words, one per cycle while
// reading that memory.
// Busy drops in the cycle of the last word, so the next request can be taken
// at the edge that ends it.
// Configuration words are written at any time on cfg_valid/cfg_ready; they
// are meant to change only while the block is idle. Reset loads the defaults
// (contrast 0xB1, bias 4) and returns the block to idle.
// ---------------------------------------------------------------------------
module lcd_text_command_stream_unit
    import lcd_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int BANKS   = BANKS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [2:0]  command,
    input  wire logic [15:0] value,
    input  wire logic [7:0]  cursor_x,
    input  wire logic [7:0]  cursor_y,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    output logic             strobe,
    output logic             is_data,
    output logic      [7:0]  byte_out,
    output logic             last
);

    typedef enum logic [2:0] { S_IDLE, S_DIGITS, S_PRIME, S_STREAM, S_FLUSH } state_t;

    state_t       state_reg;
    logic [2:0]   cmd_reg;
    logic [7:0]   val_reg;
    logic [7:0]   cx_reg, cy_reg;
    logic [5:0]   cnt_reg;
    logic [5:0]   total_reg;
    logic [7:0]   contrast_reg;
    logic [1:0]   temp_reg;
    logic [2:0]   bias_reg;
    logic         inv_reg;

    logic         dig_go, dig_done, dig_we;
    logic [DIG_AW-1:0] dig_waddr, rd_addr;
    logic [DIG_W-1:0]  dig_wdata, rd_data;
    logic         accept;
    logic [5:0]   total_now;
    logic [2:0]   pos, col;
    logic [7:0]   code;
    logic [7:0]   wbyte;
    logic         wdata_flag;

    assign accept    = start && !busy;
    assign busy      = (state_reg != S_IDLE);
    assign cfg_ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            contrast_reg <= 8'hB1;
            temp_reg     <= 2'd0;
            bias_reg     <= 3'd4;
            inv_reg      <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_CONTRAST: contrast_reg <= cfg_data;
                REG_TEMP:     temp_reg     <= cfg_data[1:0];
                REG_BIAS:     bias_reg     <= cfg_data[2:0];
                default:      inv_reg      <= cfg_data[0];
            endcase
        end
    end

    // Word count of a request.
    always_comb
    begin
        unique case (command)
            CMD_INIT:   total_now = 6'd6;
            CMD_OCTET:  total_now = 6'd1;
            CMD_CHAR:   total_now = 6'd7;
            CMD_DEC:    total_now = 6'd35;
            CMD_CURSOR: total_now = (32'(cursor_x) > COLUMNS - 1 ||
                                     32'(cursor_y) > BANKS - 1) ? 6'd0 : 6'd2;
            default:    total_now = 6'd0;
        endcase
    end

    assign dig_go = accept && (command == CMD_DEC);

    lcd_digits u_digits (
        .clk   (clk),
        .rst_n (rst_n),
        .go    (dig_go),
        .value (value),
        .done  (dig_done),
        .we    (dig_we),
        .waddr (dig_waddr),
        .wdata (dig_wdata)
    );

    lcd_ram #(.WIDTH(DIG_W), .DEPTH(DIG_DEPTH)) u_ram (
        .clk   (clk),
        .we    (dig_we),
        .waddr (dig_waddr),
        .wdata (dig_wdata),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Character position and column of the word being formed.
    always_comb
    begin
        pos = 3'd0;
        col = 3'd0;
        for (int i = 0; i < 5; i++)
        begin
            if (cnt_reg >= 6'(7 * i) && cnt_reg < 6'(7 * i + 7))
            begin
                pos = 3'(i);
                col = 3'(cnt_reg - 6'(7 * i));
            end
        end
    end

    // Read one position ahead so the data is ready in the word's cycle.
    always_comb
    begin
        rd_addr = pos;
        if (state_reg == S_STREAM && col == 3'd6 && pos != 3'd4)
        begin
            rd_addr = pos + 3'd1;
        end
        else if (state_reg != S_STREAM)
        begin
            rd_addr = 3'd0;
        end
    end

    // Word formation.
    always_comb
    begin
        code       = (cmd_reg == CMD_DEC) ? rd_data : val_reg;
        wdata_flag = 1'b1;
        wbyte      = 8'h00;
        unique case (cmd_reg)
            CMD_INIT:
            begin
                wdata_flag = 1'b0;
                unique case (cnt_reg[2:0])
                    3'd0:    wbyte = 8'h21;
                    3'd1:    wbyte = contrast_reg;
                    3'd2:    wbyte = {6'h01, temp_reg};
                    3'd3:    wbyte = {5'h02, bias_reg};
                    3'd4:    wbyte = 8'h20;
                    default: wbyte = {7'h06, inv_reg};
                endcase
            end
            CMD_OCTET:  wbyte = val_reg;
            CMD_CURSOR:
            begin
                wdata_flag = 1'b0;
                wbyte = (cnt_reg == 6'd0) ? {1'b1, cx_reg[6:0]} : {5'h08, cy_reg[2:0]};
            end
            default:
            begin
                wbyte = (col == 3'd0 || col == 3'd6) ? 8'h00
                        : glyph_col(code, col - 3'd1);
            end
        endcase
    end

    // Sequencer and registered word outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            total_reg <= '0;
            strobe    <= 1'b0;
            last      <= 1'b0;
            is_data   <= 1'b0;
            byte_out  <= '0;
        end
        else
        begin
            strobe <= 1'b0;
            last   <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        total_reg <= total_now;
                        cnt_reg   <= '0;
                        if (command == CMD_DEC)
                            state_reg <= S_DIGITS;
                        else if (total_now == 6'd0)
                            state_reg <= S_FLUSH;
                        else
                            state_reg <= S_STREAM;
                    end
                end
                S_DIGITS:
                begin
                    if (dig_done)
                        state_reg <= S_PRIME;
                end
                S_PRIME:   state_reg <= S_STREAM;
                S_STREAM:
                begin
                    strobe  <= 1'b1;
                    is_data <= wdata_flag;
                    byte_out <= wbyte;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == total_reg - 6'd1)
                    begin
                        last      <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                default:   state_reg <= S_IDLE;
            endcase
        end
    end

    // Request payload.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= command;
            val_reg <= value[7:0];
            cx_reg  <= cursor_x;
            cy_reg  <= cursor_y;
        end
    end

    // The final word of a request is always strobed.
    assert property (@(posedge clk) disable iff (!rst_n) last |-> strobe)
        else $error("last without strobe");

    // No request is taken while words are still being sent.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_STREAM) |-> busy)
        else $error("stream while idle");

    // A strobed word without last is followed by another word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !last) |=> strobe)
        else $error("gap inside a request");

endmodule
`default_nettype wire
